// File: design/sarq_pkg.sv
// Shared types and constants for the summed-area range query block.
package sarq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_LOAD_CELL = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  localparam logic [1:0] CFG_X_COUNT = 2'd0;
  localparam logic [1:0] CFG_Y_COUNT = 2'd1;
  localparam logic [1:0] CFG_TARGET_COUNT = 2'd2;

  localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

  // Saturating add or subtract on signed 64-bit values.
  function automatic logic signed [63:0] sat_op(input logic signed [63:0] a,
                                                input logic signed [63:0] b,
                                                input logic sub);
    logic signed [64:0] r;
    begin
      r = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
      if (r[64] != r[63]) begin
        sat_op = r[64] ? SUM_MIN : SUM_MAX;
      end else begin
        sat_op = r[63:0];
      end
    end
  endfunction

endpackage

// File: design/sarq_search.sv
// Binary search over a key memory: last key below (strict) or at or below a bound.
module sarq_search #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              strict_i,
  input  logic signed [31:0] bound_i,
  input  logic [IW:0]       count_i,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_addr_i,
  input  logic signed [31:0] wr_data_i,
  output logic              done_o,
  output logic signed [IW+1:0] result_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_q;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WAIT, S_CMP} state_e;
  state_e state_q;
  logic signed [IW+1:0] lo_q, hi_q;
  logic [IW-1:0] mid_q;
  logic signed [IW+1:0] mid_w;
  logic go_right;
  logic more;

  assign mid_w = (lo_q + hi_q) >>> 1;
  assign go_right = strict_i ? (rd_q < bound_i) : !(bound_i < rd_q);
  assign more = (hi_q - lo_q > 1);
  assign result_o = lo_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[mid_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lo_q <= '0;
      hi_q <= '0;
      mid_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= (state_q == S_READ) && !more;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            lo_q <= '1;
            hi_q <= $signed({1'b0, count_i});
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (more) begin
            mid_q <= mid_w[IW-1:0];
            state_q <= S_WAIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        // mid_q is now the read address; data lands at the next edge
        S_WAIT: state_q <= S_CMP;
        S_CMP: begin
          state_q <= S_READ;
          if (go_right) lo_q <= $signed({2'b00, mid_q});
          else hi_q <= $signed({2'b00, mid_q});
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/summed_area_range_query.sv
// Top level: key tables, prefix-sum memory and query sequencer.
// Cell load: three prefix memory reads plus a write.
// Query: four parallel binary searches, then four prefix memory reads per
// target plus the output step, one read per target when the range is empty;
// results leave through a one-deep output register.
// Reset clears control and count registers (counts reset to 1); the key and
// prefix memories are undefined until written.
module summed_area_range_query #(
  parameter int unsigned MAX_X_KEYS = 64,
  parameter int unsigned MAX_Y_KEYS = 64,
  parameter int unsigned MAX_TARGETS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [5:0]         key_index_i,
  input  logic signed [31:0] key_word_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  input  logic [3:0]         cell_target_i,
  input  logic signed [47:0] cell_value_i,
  input  logic signed [31:0] lower_x_bound_i,
  input  logic signed [31:0] upper_x_bound_i,
  input  logic signed [31:0] lower_y_bound_i,
  input  logic signed [31:0] upper_y_bound_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         target_number_o,
  output logic signed [63:0] range_sum_o,
  output logic               last_o
);

  localparam int unsigned XW = (MAX_X_KEYS > 1) ? $clog2(MAX_X_KEYS) : 1;
  localparam int unsigned YW = (MAX_Y_KEYS > 1) ? $clog2(MAX_Y_KEYS) : 1;
  localparam int unsigned TW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int unsigned AW = XW + YW + TW;

  // configuration, clamped when used
  logic [6:0] x_count_q, y_count_q;
  logic [4:0] target_count_q;
  logic [XW:0] nx;
  logic [YW:0] ny;
  logic [TW:0] nt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_count_q <= 7'd1;
      y_count_q <= 7'd1;
      target_count_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sarq_pkg::CFG_X_COUNT: x_count_q <= cfg_data_i;
        sarq_pkg::CFG_Y_COUNT: y_count_q <= cfg_data_i;
        sarq_pkg::CFG_TARGET_COUNT: target_count_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (x_count_q == '0) nx = (XW+1)'(1);
    else if (32'(x_count_q) > MAX_X_KEYS) nx = (XW+1)'(MAX_X_KEYS);
    else nx = (XW+1)'(x_count_q);
    if (y_count_q == '0) ny = (YW+1)'(1);
    else if (32'(y_count_q) > MAX_Y_KEYS) ny = (YW+1)'(MAX_Y_KEYS);
    else ny = (YW+1)'(y_count_q);
    if (target_count_q == '0) nt = (TW+1)'(1);
    else if (32'(target_count_q) > MAX_TARGETS) nt = (TW+1)'(MAX_TARGETS);
    else nt = (TW+1)'(target_count_q);
  end

  typedef enum logic [3:0] {
    ST_IDLE, ST_CELL_RD, ST_CELL_ACC, ST_CELL_WR, ST_SEARCH,
    ST_Q_RD, ST_Q_ACC, ST_Q_OUT
  } state_e;
  state_e state_q;

  logic in_xfer;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer = in_valid_i && in_ready_o;

  // key loads beyond the table depth are dropped
  logic kx_we, ky_we;
  assign kx_we = in_xfer && (op_i == sarq_pkg::OP_LOAD_X) && (32'(key_index_i) < MAX_X_KEYS);
  assign ky_we = in_xfer && (op_i == sarq_pkg::OP_LOAD_Y) && (32'(key_index_i) < MAX_Y_KEYS);

  logic start_q;
  logic signed [31:0] lxb_q, uxb_q, lyb_q, uyb_q;
  logic [3:0] sdone_q;
  logic [3:0] sdone;
  logic signed [XW+1:0] lx, ux;
  logic signed [YW+1:0] ly, uy;

  sarq_search #(.DEPTH(MAX_X_KEYS), .IW(XW)) u_lx (
    .clk_i, .rst_ni, .start_i(start_q), .strict_i(1'b1), .bound_i(lxb_q), .count_i(nx),
    .wr_en_i(kx_we), .wr_addr_i(key_index_i[XW-1:0]), .wr_data_i(key_word_i),
    .done_o(sdone[0]), .result_o(lx));
  sarq_search #(.DEPTH(MAX_X_KEYS), .IW(XW)) u_ux (
    .clk_i, .rst_ni, .start_i(start_q), .strict_i(1'b0), .bound_i(uxb_q), .count_i(nx),
    .wr_en_i(kx_we), .wr_addr_i(key_index_i[XW-1:0]), .wr_data_i(key_word_i),
    .done_o(sdone[1]), .result_o(ux));
  sarq_search #(.DEPTH(MAX_Y_KEYS), .IW(YW)) u_ly (
    .clk_i, .rst_ni, .start_i(start_q), .strict_i(1'b1), .bound_i(lyb_q), .count_i(ny),
    .wr_en_i(ky_we), .wr_addr_i(key_index_i[YW-1:0]), .wr_data_i(key_word_i),
    .done_o(sdone[2]), .result_o(ly));
  sarq_search #(.DEPTH(MAX_Y_KEYS), .IW(YW)) u_uy (
    .clk_i, .rst_ni, .start_i(start_q), .strict_i(1'b0), .bound_i(uyb_q), .count_i(ny),
    .wr_en_i(ky_we), .wr_addr_i(key_index_i[YW-1:0]), .wr_data_i(key_word_i),
    .done_o(sdone[3]), .result_o(uy));

  // prefix memory, one read and one write port, registered read
  logic signed [63:0] pmem [2**AW];
  logic [AW-1:0] rd_addr, wr_addr_q;
  logic pm_we;
  logic signed [63:0] pm_rd_q, wr_data_q;

  always_ff @(posedge clk_i) begin
    if (pm_we) pmem[wr_addr_q] <= wr_data_q;
    pm_rd_q <= pmem[rd_addr];
  end

  // cell / query working registers
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic [TW-1:0] ct_q;
  logic [1:0] term_q;     // which neighbor or corner is being read
  logic rd_pend_q;        // query result waiting in ST_Q_OUT (clear there after a cell write)
  logic signed [63:0] acc_q;
  logic [TW:0] t_q;
  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic use_term;         // term exists (index not -1)
  logic sub_term;

  // cell: term0 left (sub=0), term1 up (add), term2 diag (sub)
  // query: term0 uu, term1 ul (sub), term2 lu (sub), term3 ll (add)
  always_comb begin
    ax = cx_q;
    ay = cy_q;
    use_term = 1'b1;
    sub_term = 1'b0;
    if (state_q inside {ST_CELL_RD, ST_CELL_ACC}) begin
      case (term_q)
        2'd0: begin ax = cx_q - 1'b1; use_term = (cx_q != '0); end
        2'd1: begin ay = cy_q - 1'b1; use_term = (cy_q != '0); end
        default: begin
          ax = cx_q - 1'b1; ay = cy_q - 1'b1;
          use_term = (cx_q != '0) && (cy_q != '0); sub_term = 1'b1;
        end
      endcase
    end else begin
      case (term_q)
        2'd0: begin ax = ux[XW-1:0]; ay = uy[YW-1:0]; end
        2'd1: begin ax = ux[XW-1:0]; ay = ly[YW-1:0]; use_term = !ly[YW+1];
                    sub_term = 1'b1; end
        2'd2: begin ax = lx[XW-1:0]; ay = uy[YW-1:0]; use_term = !lx[XW+1];
                    sub_term = 1'b1; end
        default: begin ax = lx[XW-1:0]; ay = ly[YW-1:0];
                       use_term = !lx[XW+1] && !ly[YW+1]; end
      endcase
    end
    rd_addr = {ax, ay, (state_q inside {ST_CELL_RD, ST_CELL_ACC}) ? ct_q : t_q[TW-1:0]};
  end

  logic empty_range;
  assign empty_range = ux[XW+1] || uy[YW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      start_q <= 1'b0;
      sdone_q <= '0;
      pm_we <= 1'b0;
      out_valid_o <= 1'b0;
      term_q <= '0;
      t_q <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      start_q <= in_xfer && (op_i == sarq_pkg::OP_QUERY);
      pm_we <= (state_q == ST_CELL_WR);
      // a result loaded in ST_Q_OUT this cycle keeps valid high
      if (out_valid_o && out_ready_i && !(state_q == ST_Q_OUT && rd_pend_q))
        out_valid_o <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && op_i == sarq_pkg::OP_LOAD_CELL) begin
            if (32'(cell_x_i) < 32'(nx) && 32'(cell_y_i) < 32'(ny) &&
                32'(cell_target_i) < 32'(nt)) begin
              cx_q <= cell_x_i[XW-1:0];
              cy_q <= cell_y_i[YW-1:0];
              ct_q <= cell_target_i[TW-1:0];
              acc_q <= 64'(cell_value_i);
              term_q <= '0;
              state_q <= ST_CELL_RD;
            end
          end else if (in_xfer && op_i == sarq_pkg::OP_QUERY) begin
            lxb_q <= lower_x_bound_i;
            uxb_q <= upper_x_bound_i;
            lyb_q <= lower_y_bound_i;
            uyb_q <= upper_y_bound_i;
            sdone_q <= '0;
            state_q <= ST_SEARCH;
          end
        end
        ST_CELL_RD: state_q <= ST_CELL_ACC;   // address held, data next
        ST_CELL_ACC: begin
          if (use_term) acc_q <= sarq_pkg::sat_op(acc_q, pm_rd_q, sub_term);
          if (term_q == 2'd2) begin
            state_q <= ST_CELL_WR;
          end else begin
            term_q <= term_q + 2'd1;
            state_q <= ST_CELL_RD;
          end
        end
        ST_CELL_WR: begin
          wr_addr_q <= {cx_q, cy_q, ct_q};
          wr_data_q <= acc_q;
          state_q <= ST_Q_OUT;   // pass through ST_Q_OUT so the write lands
          t_q <= '0;
        end
        ST_SEARCH: begin
          if ((sdone_q | sdone) == 4'hF) begin
            state_q <= ST_Q_RD;
            t_q <= '0;
            term_q <= '0;
          end
          sdone_q <= sdone_q | sdone;
        end
        ST_Q_RD: begin
          if (!out_valid_o || out_ready_i) begin
            state_q <= ST_Q_ACC;
          end
        end
        ST_Q_ACC: begin
          if (term_q == 2'd0) acc_q <= pm_rd_q;
          else if (use_term) acc_q <= sarq_pkg::sat_op(acc_q, pm_rd_q, sub_term);
          if (term_q == 2'd3 || empty_range) begin
            state_q <= ST_Q_OUT;
            rd_pend_q <= 1'b1;
          end else begin
            term_q <= term_q + 2'd1;
            state_q <= ST_Q_RD;
          end
        end
        ST_Q_OUT: begin
          if (!rd_pend_q) begin
            state_q <= ST_IDLE;   // end of a cell write
          end else if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            target_number_o <= 4'(t_q);
            range_sum_o <= empty_range ? 64'sd0 : acc_q;
            last_o <= (t_q == nt - 1'b1);
            rd_pend_q <= 1'b0;
            term_q <= '0;
            if (t_q == nt - 1'b1) begin
              state_q <= ST_IDLE;
            end else begin
              t_q <= t_q + 1'b1;
              state_q <= ST_Q_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // no new transfer while a query is still emitting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_RD || state_q == ST_Q_ACC) |-> !in_ready_o)
    else $error("input taken during query");

  // a result held back keeps its sum and last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(range_sum_o) && $stable(last_o))
    else $error("result changed while stalled");

  // prefix writes only come out of the cell path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pm_we |-> $past(state_q) == ST_CELL_WR)
    else $error("stray prefix write");

endmodule

// File: tb/sv/range_sum_checker.sv
// Checker for the summed-area range query block: predicts every rectangle sum and compares.
`timescale 1ns / 100ps
module range_sum_checker
  import sarq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         op_i,
  input  logic [5:0]         key_index_i,
  input  logic signed [31:0] key_word_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  input  logic [3:0]         cell_target_i,
  input  logic signed [47:0] cell_value_i,
  input  logic signed [31:0] lower_x_bound_i,
  input  logic signed [31:0] upper_x_bound_i,
  input  logic signed [31:0] lower_y_bound_i,
  input  logic signed [31:0] upper_y_bound_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [3:0]         target_number_i,
  input  logic signed [63:0] range_sum_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [3:0]         tgt;
    logic signed [63:0] sum;
    logic               last;
  } sum_rec_t;

  sum_rec_t           expected_sums[$];
  logic signed [31:0] x_keys[64];
  logic signed [31:0] y_keys[64];
  logic signed [63:0] prefix_mem[65536];
  logic [6:0]         x_cnt_q = 7'd1;
  logic [6:0]         y_cnt_q = 7'd1;
  logic [4:0]         t_cnt_q = 5'd1;
  int                 fails = 0;

  assign fail_count_o = fails;

  function automatic int clamp(input int v, input int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [63:0] sat_step(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input logic sub);
    logic signed [64:0] r;
    r = sub ? ($signed({a[63], a}) - $signed({b[63], b}))
            : ($signed({a[63], a}) + $signed({b[63], b}));
    if (r > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SUM_MAX;
    if (r < -65'sh0_8000_0000_0000_0000) return SUM_MIN;
    return r[63:0];
  endfunction

  function automatic int addr(input int x, input int y, input int t);
    return (x * 64 + y) * 16 + t;
  endfunction

  function automatic logic signed [63:0] prefix_at(input int x, input int y, input int t);
    if (x < 0 || y < 0) return 64'sd0;
    return prefix_mem[addr(x, y, t)];
  endfunction

  // last key < bound (strict) or <= bound; -1 if none
  function automatic int key_search(input logic is_x, input int n,
                                    input logic signed [31:0] bound, input logic strict);
    int lo, hi, mid;
    logic signed [31:0] k;
    logic right;
    lo = -1;
    hi = n;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      k = is_x ? x_keys[mid] : y_keys[mid];
      right = strict ? (k < bound) : !(bound < k);
      if (right) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  task automatic report(input string what);
    $display("[%0t] range sum check: %s", $time, what);
    fails++;
  endtask

  task automatic take_item();
    int nx, ny, nt, cx, cy, ct, lx, ux, ly, uy;
    logic signed [63:0] v;
    sum_rec_t rec;
    nx = clamp(x_cnt_q, 64);
    ny = clamp(y_cnt_q, 64);
    nt = clamp(t_cnt_q, 16);
    case (op_e'(op_i))
      OP_LOAD_X: x_keys[key_index_i] = key_word_i;
      OP_LOAD_Y: y_keys[key_index_i] = key_word_i;
      OP_LOAD_CELL: begin
        cx = cell_x_i;
        cy = cell_y_i;
        ct = cell_target_i;
        if (cx < nx && cy < ny && ct < nt) begin
          v = 64'(cell_value_i);
          v = sat_step(v, prefix_at(cx - 1, cy, ct), 1'b0);
          v = sat_step(v, prefix_at(cx, cy - 1, ct), 1'b0);
          v = sat_step(v, prefix_at(cx - 1, cy - 1, ct), 1'b1);
          prefix_mem[addr(cx, cy, ct)] = v;
        end
      end
      default: begin
        lx = key_search(1'b1, nx, lower_x_bound_i, 1'b1);
        ux = key_search(1'b1, nx, upper_x_bound_i, 1'b0);
        ly = key_search(1'b0, ny, lower_y_bound_i, 1'b1);
        uy = key_search(1'b0, ny, upper_y_bound_i, 1'b0);
        for (int t = 0; t < nt; t++) begin
          v = 64'sd0;
          if (ux >= 0 && uy >= 0) begin
            v = prefix_at(ux, uy, t);
            if (ly >= 0) v = sat_step(v, prefix_at(ux, ly, t), 1'b1);
            if (lx >= 0) v = sat_step(v, prefix_at(lx, uy, t), 1'b1);
            if (lx >= 0 && ly >= 0) v = sat_step(v, prefix_at(lx, ly, t), 1'b0);
          end
          rec.tgt = 4'(t);
          rec.sum = v;
          rec.last = (t == nt - 1);
          expected_sums.insert(expected_sums.size(), rec);
        end
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    sum_rec_t exp_rec;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_X_COUNT:      x_cnt_q = cfg_data_i;
          CFG_Y_COUNT:      y_cnt_q = cfg_data_i;
          CFG_TARGET_COUNT: t_cnt_q = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) take_item();
      if (out_valid_i && out_ready_i) begin
        if (expected_sums.size() == 0) begin
          report($sformatf("unexpected result target %0d sum %0d", target_number_i,
                           range_sum_i));
        end else begin
          exp_rec = expected_sums.pop_front();
          if (target_number_i !== exp_rec.tgt)
            report($sformatf("target_number %0d, want %0d", target_number_i, exp_rec.tgt));
          if (range_sum_i !== exp_rec.sum)
            report($sformatf("range_sum %0d, want %0d (target %0d)", range_sum_i,
                             exp_rec.sum, exp_rec.tgt));
          if (last_i !== exp_rec.last)
            report($sformatf("last %0b, want %0b (target %0d)", last_i, exp_rec.last,
                             exp_rec.tgt));
        end
      end
    end
    pending_o <= expected_sums.size();
  end

endmodule

// File: tb/sv/testbench.sv
// Top of the testbench: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps
module testbench;
  import sarq_pkg::*;

  localparam int LIMIT = 1_500_000;  // cycles, several times the slowest clean run
  localparam int SETTLE = 40;        // covers a cell load still in flight

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [6:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         op_i;
  logic [5:0]         key_index_i;
  logic signed [31:0] key_word_i;
  logic [5:0]         cell_x_i;
  logic [5:0]         cell_y_i;
  logic [3:0]         cell_target_i;
  logic signed [47:0] cell_value_i;
  logic signed [31:0] lower_x_bound_i;
  logic signed [31:0] upper_x_bound_i;
  logic signed [31:0] lower_y_bound_i;
  logic signed [31:0] upper_y_bound_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [3:0]         target_number_o;
  logic signed [63:0] range_sum_o;
  logic               last_o;

  int fail_count;
  int pending;
  int cycles = 0;

  // quiet: no idling on either side; hold_req: ask the receiver for one long stall
  bit quiet = 0;
  bit hold_req = 0;

  // stimulus-side copy of the keys, only to aim query bounds near real keys
  int xk[64];
  int yk[64];
  int nx = 1, ny = 1, nt = 1;

  summed_area_range_query dut (.*);

  range_sum_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .op_i, .key_index_i, .key_word_i,
    .cell_x_i, .cell_y_i, .cell_target_i, .cell_value_i,
    .lower_x_bound_i, .upper_x_bound_i, .lower_y_bound_i, .upper_y_bound_i,
    .out_valid_i(out_valid_o), .out_ready_i, .target_number_i(target_number_o),
    .range_sum_i(range_sum_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random ready bursts, one long stall on request, always ready when quiet.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (quiet) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
    end
  end

  function automatic logic signed [47:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 48'sh7FFF_FFFF_FFFF;
      1: return 48'sh8000_0000_0000;
      2: return 48'(signed'($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // Bound near a live key (one below, on, one above), else anywhere.
  function automatic int pick_bound(input bit is_x);
    int k;
    if ($urandom_range(0, 4) == 0) return int'($urandom);
    k = is_x ? xk[$urandom_range(0, nx - 1)] : yk[$urandom_range(0, ny - 1)];
    return k + $urandom_range(0, 2) - 1;
  endfunction

  // One transfer on the input channel; unused fields carry random bits.
  task automatic drive(input op_e op, input logic [5:0] ki, input int kw,
                       input logic [5:0] cx, input logic [5:0] cy, input logic [3:0] ct,
                       input logic signed [47:0] cv,
                       input int lxb, input int uxb, input int lyb, input int uyb);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    key_index_i <= ki;
    key_word_i <= kw;
    cell_x_i <= cx;
    cell_y_i <= cy;
    cell_target_i <= ct;
    cell_value_i <= cv;
    lower_x_bound_i <= lxb;
    upper_x_bound_i <= uxb;
    lower_y_bound_i <= lyb;
    upper_y_bound_i <= uyb;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic load_key(input bit is_x, input int idx, input int kw);
    if (is_x) xk[idx] = kw;
    else yk[idx] = kw;
    drive(is_x ? OP_LOAD_X : OP_LOAD_Y, 6'(idx), kw, 6'($urandom), 6'($urandom),
          4'($urandom), 48'($urandom), $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic load_cell(input int x, input int y, input int t,
                           input logic signed [47:0] v);
    drive(OP_LOAD_CELL, 6'($urandom), $urandom, 6'(x), 6'(y), 4'(t), v,
          $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic query(input int lxb, input int uxb, input int lyb, input int uyb);
    drive(OP_QUERY, 6'($urandom), $urandom, 6'($urandom), 6'($urandom), 4'($urandom),
          48'($urandom), lxb, uxb, lyb, uyb);
  endtask

  // Lower valid, wait for every expected sum, then let a trailing cell load finish.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Block is idle here: write the three counts, then key tables and the full grid.
  task automatic setup_phase(input int xr, input int yr, input int tr, input bit wide_keys);
    int kx, ky;
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_X_COUNT;
    cfg_data_i <= 7'(xr);
    @(posedge clk_i);
    cfg_index_i <= CFG_Y_COUNT;
    cfg_data_i <= 7'(yr);
    @(posedge clk_i);
    cfg_index_i <= CFG_TARGET_COUNT;
    cfg_data_i <= 7'(tr);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nx = (xr < 1) ? 1 : (xr > 64) ? 64 : xr;
    ny = (yr < 1) ? 1 : (yr > 64) ? 64 : yr;
    nt = (tr < 1) ? 1 : (tr > 16) ? 16 : tr;
    kx = -(1 << 30) + $urandom_range(0, 1 << 20);
    ky = -(1 << 30) + $urandom_range(0, 1 << 20);
    for (int i = 0; i < nx; i++) begin
      // wide_keys pins the table ends at the 32-bit extremes
      if (wide_keys && i == 0) load_key(1, i, 32'sh8000_0000);
      else if (wide_keys && i == nx - 1 && i > 0) load_key(1, i, 32'sh7FFF_FFFF);
      else load_key(1, i, kx);
      kx += $urandom_range(1, 1 << 24);
    end
    for (int i = 0; i < ny; i++) begin
      if (wide_keys && i == 0) load_key(0, i, 32'sh8000_0000);
      else if (wide_keys && i == ny - 1 && i > 0) load_key(0, i, 32'sh7FFF_FFFF);
      else load_key(0, i, ky);
      ky += $urandom_range(1, 1 << 24);
    end
    // raster order: x, then y, then target
    for (int x = 0; x < nx; x++)
      for (int y = 0; y < ny; y++)
        for (int t = 0; t < nt; t++)
          load_cell(x, y, t, pick_value());
  endtask

  // Mostly queries over a fully loaded grid; some reloads, key rewrites and ignored cells.
  task automatic random_items(input int n, input bit with_hold);
    int r;
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 3) hold_req = 1;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        query(pick_bound(1), pick_bound(1), pick_bound(0), pick_bound(0));
      end else if (r < 75) begin
        load_cell($urandom_range(0, nx - 1), $urandom_range(0, ny - 1),
                  $urandom_range(0, nt - 1), pick_value());
      end else if (r < 85) begin
        // any index is safe: searches only read inside the count
        load_key($urandom_range(0, 1), $urandom_range(0, 63),
                 ($urandom_range(0, 1) != 0) ? int'($urandom) : pick_bound(1));
      end else begin
        load_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 15),
                  pick_value());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_X_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = OP_LOAD_X;
    key_index_i = '0;
    key_word_i = '0;
    cell_x_i = '0;
    cell_y_i = '0;
    cell_target_i = '0;
    cell_value_i = '0;
    lower_x_bound_i = '0;
    upper_x_bound_i = '0;
    lower_y_bound_i = '0;
    upper_y_bound_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset counts of one key, one key, one target.
    load_key(1, 0, 0);
    load_key(0, 0, 0);
    load_cell(0, 0, 0, 48'sh7FFF_FFFF_FFFF);
    query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    query(32'sh8000_0000, -1, 32'sh8000_0000, 32'sh7FFF_FFFF);   // empty x range
    query(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);    // lower term only
    load_key(1, 63, 32'sh7FFF_FFFF);                             // stored, not searched
    load_cell(5, 0, 0, 48'sh1234_5678_9ABC);                     // outside grid, dropped
    load_cell(0, 0, 15, 48'sh1234_5678_9ABC);                    // target outside count
    load_cell(0, 0, 0, 48'sh8000_0000_0000);
    query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    load_key(0, 0, 32'sh8000_0000);
    query(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    load_key(0, 0, 32'sh7FFF_FFFF);
    query(0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    query(-5, 5, 32'sh7FFF_FFFE, 32'sh7FFF_FFFE);                // empty y range
    drain();

    // Phases: small grids, clamped counts and the table extremes.
    setup_phase(3, 2, 2, 0);
    random_items(20, 1);
    drain();
    setup_phase(127, 0, 1, 1);   // counts clamp to 64 and 1
    random_items(20, 0);
    drain();
    setup_phase(0, 5, 3, 1);     // x count clamps to 1
    random_items(20, 0);
    drain();
    setup_phase(1, 1, 31, 0);    // target count clamps to 16
    random_items(20, 0);
    drain();
    setup_phase(2, 2, 5, 0);
    random_items(20, 0);
    drain();
    setup_phase($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3), 1);
    random_items(20, 0);
    drain();
    setup_phase(3, 3, 2, 0);
    quiet = 1;
    random_items(20, 0);
    drain();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: summed_area_range_query.f
design/sarq_pkg.sv
design/sarq_search.sv
design/summed_area_range_query.sv
tb/sv/range_sum_checker.sv
tb/sv/testbench.sv
